/* rtl/core/trp_pkg.sv */
package trp_pkg;

   localparam int ADDR_WIDTH  = 32;
   localparam int INDEX_WIDTH = 16;

   // character classes seen by the parser
   typedef enum logic [2:0] {
      CH_OTHER,
      CH_NUL,
      CH_DIGIT,
      CH_QUOTE,
      CH_COMMA,
      CH_LBRACK,
      CH_RBRACK,
      CH_RBRACE
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
   } token_type;

   localparam logic [1:0] KIND_BTIME  = 2'd0;
   localparam logic [1:0] KIND_INPUT  = 2'd1;
   localparam logic [1:0] KIND_OUTPUT = 2'd2;

endpackage

/* rtl/core/trp_front.sv */
module trp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_in,
   output logic               tok_valid,
   input  logic               tok_ready,
   output trp_pkg::token_type tok
);

   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_COMMA  = 8'h2C;
   localparam logic [7:0] CHR_LBRACK = 8'h5B;
   localparam logic [7:0] CHR_RBRACK = 8'h5D;
   localparam logic [7:0] CHR_RBRACE = 8'h7D;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;

   logic               valid_ff;
   logic               valid_in;
   trp_pkg::token_type tok_ff;
   trp_pkg::token_type tok_in;
   logic               take;

   assign req_ready = !valid_ff || tok_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      tok_in.digit = req_char_in[3:0];
      unique case (req_char_in)
         CHR_NUL:    tok_in.cls = trp_pkg::CH_NUL;
         CHR_QUOTE:  tok_in.cls = trp_pkg::CH_QUOTE;
         CHR_COMMA:  tok_in.cls = trp_pkg::CH_COMMA;
         CHR_LBRACK: tok_in.cls = trp_pkg::CH_LBRACK;
         CHR_RBRACK: tok_in.cls = trp_pkg::CH_RBRACK;
         CHR_RBRACE: tok_in.cls = trp_pkg::CH_RBRACE;
         default: begin
            if (req_char_in >= CHR_ZERO && req_char_in <= CHR_NINE)
               tok_in.cls = trp_pkg::CH_DIGIT;
            else
               tok_in.cls = trp_pkg::CH_OTHER;
         end
      endcase
   end

   assign valid_in = take ? 1'b1 : (valid_ff && !tok_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take)
         tok_ff <= tok_in;
   end

   assign tok_valid = valid_ff;
   assign tok       = tok_ff;

endmodule

/* rtl/core/trp_queue.sv */
module trp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  trp_pkg::token_type push_tok,
   output logic               pop_valid,
   input  logic               pop_ready,
   output trp_pkg::token_type pop_tok
);

   trp_pkg::token_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_tok    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 2'd1;
      else if (pop && !push)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push)
         slot_ff[wr_ptr_ff] <= push_tok;
   end

endmodule

/* rtl/core/trp_back.sv */
module trp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               tok_valid,
   output logic               tok_ready,
   input  trp_pkg::token_type tok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [15:0]        rsp_entry_index,
   output logic [31:0]        rsp_address_id,
   output logic [63:0]        rsp_amount,
   output logic               rsp_last
);

   localparam int AW = trp_pkg::ADDR_WIDTH;
   localparam int IW = trp_pkg::INDEX_WIDTH;

   localparam logic [3:0] SKIP_BTIME  = 4'd11;
   localparam logic [3:0] SKIP_FEE    = 4'd6;
   localparam logic [3:0] SKIP_LIST   = 4'd9;
   localparam logic [3:0] SKIP_INPUTS = 4'd7;
   localparam logic [3:0] SKIP_ENTRY  = 4'd11;
   localparam logic [3:0] SKIP_VALUE  = 4'd9;

   typedef enum logic [2:0] {
      PH_START,
      PH_BTIME,
      PH_FEE,
      PH_LIST,
      PH_ENTRY,
      PH_NUM,
      PH_AFTER,
      PH_DONE
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [3:0]      skip_ff, skip_in;
   logic            first_ff, first_in;
   logic            in_out_ff, in_out_in;
   logic [63:0]     accum_ff, accum_in;
   logic            addr_done_ff, addr_done_in;
   logic [AW-1:0]   addr_hold_ff, addr_hold_in;
   logic [IW-1:0]   in_cnt_ff, in_cnt_in;
   logic [IW-1:0]   out_cnt_ff, out_cnt_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      kind_ff, kind_in;
   logic [15:0]     index_ff, index_in;
   logic [31:0]     addr_ff, addr_in;
   logic [63:0]     amount_ff, amount_in;
   logic            last_ff, last_in;

   logic            pop;
   logic            emit;
   logic            is_digit;
   logic [63:0]     accum_step;

   assign tok_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = tok_valid && tok_ready;
   assign is_digit  = (tok.cls == trp_pkg::CH_DIGIT);
   // x*10 + d as two shifted terms
   assign accum_step = {accum_ff[60:0], 3'b000} + {accum_ff[62:0], 1'b0}
                       + 64'(tok.digit);

   always_comb begin
      phase_in     = phase_ff;
      skip_in      = skip_ff;
      first_in     = first_ff;
      in_out_in    = in_out_ff;
      accum_in     = accum_ff;
      addr_done_in = addr_done_ff;
      addr_hold_in = addr_hold_ff;
      in_cnt_in    = in_cnt_ff;
      out_cnt_in   = out_cnt_ff;
      emit         = 1'b0;
      kind_in      = kind_ff;
      index_in     = index_ff;
      addr_in      = addr_ff;
      amount_in    = amount_ff;
      last_in      = last_ff;

      if (pop) begin
         if (tok.cls == trp_pkg::CH_NUL) begin
            phase_in     = PH_START;
            skip_in      = 4'd0;
            first_in     = 1'b0;
            in_out_in    = 1'b0;
            accum_in     = 64'd0;
            addr_done_in = 1'b0;
            addr_hold_in = '0;
            in_cnt_in    = '0;
            out_cnt_in   = '0;
         end else if (skip_ff != 4'd0) begin
            skip_in = skip_ff - 4'd1;
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  if (!first_ff) begin
                     first_in = 1'b1;
                  end else if (tok.cls == trp_pkg::CH_QUOTE) begin
                     phase_in = PH_BTIME;
                     skip_in  = SKIP_BTIME;
                     accum_in = 64'd0;
                  end
               end
               PH_BTIME: begin
                  if (tok.cls == trp_pkg::CH_COMMA) begin
                     emit      = 1'b1;
                     kind_in   = trp_pkg::KIND_BTIME;
                     index_in  = 16'd0;
                     addr_in   = 32'd0;
                     amount_in = accum_ff;
                     last_in   = 1'b0;
                     phase_in  = PH_FEE;
                     skip_in   = SKIP_FEE;
                  end else if (is_digit) begin
                     accum_in = accum_step;
                  end
               end
               PH_FEE: begin
                  if (tok.cls == trp_pkg::CH_COMMA) begin
                     phase_in  = PH_LIST;
                     in_out_in = 1'b0;
                     skip_in   = SKIP_LIST;
                  end
               end
               PH_LIST: begin
                  if (tok.cls == trp_pkg::CH_LBRACK) begin
                     phase_in = PH_ENTRY;
                     skip_in  = SKIP_ENTRY;
                  end else begin
                     skip_in = in_out_ff ? SKIP_ENTRY : SKIP_INPUTS;
                  end
               end
               PH_ENTRY: begin
                  if (tok.cls == trp_pkg::CH_LBRACK) begin
                     phase_in     = PH_NUM;
                     addr_done_in = 1'b0;
                     accum_in     = 64'd0;
                  end else begin
                     skip_in = SKIP_ENTRY;
                  end
               end
               PH_NUM: begin
                  if (!addr_done_ff && tok.cls == trp_pkg::CH_RBRACK) begin
                     addr_hold_in = accum_ff[AW-1:0];
                     addr_done_in = 1'b1;
                     accum_in     = 64'd0;
                     skip_in      = SKIP_VALUE;
                  end else if (addr_done_ff && tok.cls == trp_pkg::CH_RBRACE) begin
                     phase_in = PH_AFTER;
                  end else if (is_digit) begin
                     accum_in = accum_step;
                  end
               end
               PH_AFTER: begin
                  emit      = 1'b1;
                  addr_in   = 32'(addr_hold_ff);
                  amount_in = accum_ff;
                  if (in_out_ff) begin
                     kind_in    = trp_pkg::KIND_OUTPUT;
                     index_in   = 16'(out_cnt_ff);
                     last_in    = (tok.cls == trp_pkg::CH_RBRACK);
                     out_cnt_in = (out_cnt_ff != '1) ? out_cnt_ff + IW'(1) : out_cnt_ff;
                  end else begin
                     kind_in   = trp_pkg::KIND_INPUT;
                     index_in  = 16'(in_cnt_ff);
                     last_in   = 1'b0;
                     in_cnt_in = (in_cnt_ff != '1) ? in_cnt_ff + IW'(1) : in_cnt_ff;
                  end
                  addr_done_in = 1'b0;
                  if (tok.cls == trp_pkg::CH_RBRACK) begin
                     if (in_out_ff) begin
                        phase_in = PH_DONE;
                     end else begin
                        in_out_in = 1'b1;
                        phase_in  = PH_LIST;
                        skip_in   = SKIP_ENTRY;
                     end
                  end else begin
                     phase_in = PH_ENTRY;
                     skip_in  = SKIP_ENTRY;
                  end
               end
               PH_DONE: begin
               end
            endcase
         end
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         skip_ff      <= 4'd0;
         first_ff     <= 1'b0;
         in_out_ff    <= 1'b0;
         accum_ff     <= 64'd0;
         addr_done_ff <= 1'b0;
         addr_hold_ff <= '0;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         skip_ff      <= skip_in;
         first_ff     <= first_in;
         in_out_ff    <= in_out_in;
         accum_ff     <= accum_in;
         addr_done_ff <= addr_done_in;
         addr_hold_ff <= addr_hold_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff   <= kind_in;
      index_ff  <= index_in;
      addr_ff   <= addr_in;
      amount_ff <= amount_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_entry_index = index_ff;
   assign rsp_address_id  = addr_ff;
   assign rsp_amount      = amount_ff;
   assign rsp_last        = last_ff;

   a_nul_restarts: assert property (@(posedge clock) disable iff (reset)
      pop && tok.cls == trp_pkg::CH_NUL |=> phase_ff == PH_START && skip_ff == 4'd0
         && !first_ff && in_cnt_ff == '0 && out_cnt_ff == '0)
      else $error("zero byte did not restart the parser");

   a_last_on_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> kind_ff == trp_pkg::KIND_OUTPUT)
      else $error("last flag on a non-output record");

   a_btime_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == trp_pkg::KIND_BTIME |-> addr_ff == 32'd0
         && index_ff == 16'd0 && !last_ff)
      else $error("blocktime record with nonzero entry fields");

   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      pop && skip_ff != 4'd0 && tok.cls != trp_pkg::CH_NUL
         |=> skip_ff == $past(skip_ff) - 4'd1 && phase_ff == $past(phase_ff))
      else $error("skipped character changed the parse phase");

endmodule

/* rtl/core/transaction_record_parser_unit.sv */
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_char_in[7:0]
// rsp       out        rsp_valid/rsp_ready  rsp_kind, rsp_entry_index, rsp_address_id,
//                                           rsp_amount, rsp_last
//
// One character per clock sustained while rsp is accepted; a character reaches the rsp
// register through the classify stage, the 2-entry queue and the parser stage.
// The rate is set by the parser state update, a 64-bit multiply-by-ten accumulate.
// Synchronous active-high reset returns the parser to record start; no clearing pass.
// A stalled rsp holds the parser; the queue and front keep taking characters until full.
module transaction_record_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_entry_index,
   output logic [31:0] rsp_address_id,
   output logic [63:0] rsp_amount,
   output logic        rsp_last
);

   trp_pkg::token_type front_tok;
   logic               front_valid, front_ready;
   trp_pkg::token_type back_tok;
   logic               back_valid, back_ready;

   trp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .tok_valid   (front_valid),
      .tok_ready   (front_ready),
      .tok         (front_tok)
   );

   trp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_tok   (front_tok),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_tok    (back_tok)
   );

   trp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .tok_valid       (back_valid),
      .tok_ready       (back_ready),
      .tok             (back_tok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_entry_index (rsp_entry_index),
      .rsp_address_id  (rsp_address_id),
      .rsp_amount      (rsp_amount),
      .rsp_last        (rsp_last)
   );

endmodule
